>>> design/lkd_pkg.sv
package lkd_pkg;

    localparam int NUM_KEYS           = 14;
    localparam int WINDOW             = 11;
    localparam int LINE_LIMIT_DEFAULT = 100;
    localparam int LED_W              = 3;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;

    // Keyword indexes, in the bit order of keyword_hits.
    localparam int KEY_FAIL     = 0;
    localparam int KEY_NO_AP    = 1;
    localparam int KEY_STATUS5  = 2;
    localparam int KEY_GOT_IP   = 3;
    localparam int KEY_CWJAP    = 4;
    localparam int KEY_CLOSED   = 5;
    localparam int KEY_STATUS3  = 6;
    localparam int KEY_STATUS2  = 7;
    localparam int KEY_STATUS4  = 8;
    localparam int KEY_SEND     = 9;
    localparam int KEY_CMD1     = 10;
    localparam int KEY_CMD2     = 11;
    localparam int KEY_CMD3     = 12;
    localparam int KEY_CMD4     = 13;

    localparam logic [LED_W-1:0] LED_NONE = 3'd0;
    localparam logic [LED_W-1:0] LED_CMD1 = 3'd1;
    localparam logic [LED_W-1:0] LED_CMD2 = 3'd2;
    localparam logic [LED_W-1:0] LED_CMD3 = 3'd3;
    localparam logic [LED_W-1:0] LED_CMD4 = 3'd4;

    typedef logic [WINDOW-1:0][7:0] window_t;
    typedef logic [NUM_KEYS-1:0]    hits_t;
    typedef logic [3:0]             key_len_t;

    typedef struct packed {
        hits_t             keyword_hits;
        logic              wifi_reinit;
        logic              server_connect;
        logic              start_send;
        logic [LED_W-1:0]  led_command;
    } result_t;

    // String literals are right aligned, so byte 0 holds the last character
    // of a keyword and lines up with the newest entry of the window.
    localparam window_t KEY_TEXT [NUM_KEYS] = '{
        window_t'("FAIL"),     window_t'("No AP"),    window_t'("STATUS:5"),
        window_t'("WIFI GOT IP"), window_t'("+CWJAP:"), window_t'("CLOSED"),
        window_t'("STATUS:3"), window_t'("STATUS:2"), window_t'("STATUS:4"),
        window_t'("Send"),     window_t'("Command1"), window_t'("Command2"),
        window_t'("Command3"), window_t'("Command4")
    };

    localparam key_len_t KEY_LEN [NUM_KEYS] = '{
        4'd4, 4'd5, 4'd8, 4'd11, 4'd7, 4'd6, 4'd8, 4'd8, 4'd8, 4'd4,
        4'd8, 4'd8, 4'd8, 4'd8
    };

    function automatic logic key_match(input window_t win, input int unsigned k);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < WINDOW; i++) begin
            if ((i < int'(KEY_LEN[k])) && (win[i] != KEY_TEXT[k][i])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic result_t make_result(input hits_t h);
        result_t r;
        r.keyword_hits   = h;
        r.wifi_reinit    = h[KEY_FAIL] | h[KEY_NO_AP] | h[KEY_STATUS5] | h[KEY_GOT_IP];
        r.server_connect = h[KEY_CWJAP] | h[KEY_CLOSED] | h[KEY_STATUS2] | h[KEY_STATUS4];
        r.start_send     = h[KEY_STATUS3] | h[KEY_SEND];
        if (h[KEY_CMD4]) begin
            r.led_command = LED_CMD4;
        end else if (h[KEY_CMD3]) begin
            r.led_command = LED_CMD3;
        end else if (h[KEY_CMD2]) begin
            r.led_command = LED_CMD2;
        end else if (h[KEY_CMD1]) begin
            r.led_command = LED_CMD1;
        end else begin
            r.led_command = LED_NONE;
        end
        return r;
    endfunction

endpackage

>>> design/lkd_in_stage.sv
module lkd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       stage_valid,
    output logic [7:0] stage_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready    = !valid_reg || advance;
    assign valid_next  = (in_valid && in_ready) || (valid_reg && !advance);
    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

>>> design/lkd_line_tracker.sv
module lkd_line_tracker #(
    parameter int LINE_LIMIT = lkd_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      stage_byte,
    input  logic            stage_valid,
    input  logic            advance,
    output logic            emit,
    output lkd_pkg::result_t result
);
    import lkd_pkg::*;

    localparam int CNT_W = $clog2(LINE_LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LINE_LIMIT);

    window_t          window_reg;
    window_t          window_next;
    window_t          shifted;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    hits_t            hits_reg;
    hits_t            hits_next;
    hits_t            new_hits;
    logic             line_full;
    logic             is_term;
    logic             is_print;

    assign line_full = (count_reg >= LIMIT);
    assign is_term   = (stage_byte == CHAR_CR) || (stage_byte == CHAR_LF);
    assign is_print  = (stage_byte >= PRINT_LO) && (stage_byte <= PRINT_HI);
    assign emit      = stage_valid && !line_full && is_term;
    assign result    = make_result(hits_reg);
    assign shifted   = {window_reg[WINDOW-2:0], stage_byte};

    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            new_hits[k] = key_match(shifted, k);
        end
    end

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        hits_next   = hits_reg;
        if (line_full || is_term)
        begin
            // A full line is dropped without a result; a terminator ends it.
            window_next = '0;
            count_next  = '0;
            hits_next   = '0;
        end
        else if (is_print)
        begin
            window_next = shifted;
            count_next  = count_reg + 1'b1;
            hits_next   = hits_reg | new_hits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            hits_reg   <= '0;
        end
        else if (advance)
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            hits_reg   <= hits_next;
        end
    end

endmodule

>>> design/lkd_out_reg.sv
module lkd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lkd_pkg::result_t load_data,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output lkd_pkg::result_t out_data
);
    import lkd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> design/line_keyword_detector_top.sv
// Line keyword detector. Takes one received serial byte per transaction and
// assembles printable bytes into a line of at most LINE_LIMIT characters,
// flagging 14 fixed keywords seen in the line through parallel compares on
// an 11-character history. CR or LF yields one result transaction with the
// keyword flags and the derived actions, then starts a new line; a byte that
// arrives at a full line discards the line with no result. Each byte waits
// in the input register, and the line state and result register update as
// it leaves, so a byte is accepted every cycle and a terminator reaches the
// output through the input register and then the result register; only a
// stalled result that meets a new terminator holds the input side.
module line_keyword_detector_top #(
    parameter int LINE_LIMIT = lkd_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [lkd_pkg::NUM_KEYS-1:0] keyword_hits,
    output logic                      wifi_reinit,
    output logic                      server_connect,
    output logic                      start_send,
    output logic [lkd_pkg::LED_W-1:0] led_command
);
    import lkd_pkg::*;

    logic       stage_valid;
    logic [7:0] stage_byte;
    logic       advance;
    logic       emit;
    logic       slot_free;
    result_t    line_result;
    result_t    out_data;

    assign advance = stage_valid && (!emit || slot_free);

    lkd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    lkd_line_tracker #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_byte  (stage_byte),
        .stage_valid (stage_valid),
        .advance     (advance),
        .emit        (emit),
        .result      (line_result)
    );

    lkd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit && advance),
        .load_data (line_result),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign keyword_hits   = out_data.keyword_hits;
    assign wifi_reinit    = out_data.wifi_reinit;
    assign server_connect = out_data.server_connect;
    assign start_send     = out_data.start_send;
    assign led_command    = out_data.led_command;

endmodule

>>> design/lkd_checker.sv
module lkd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lkd_pkg::NUM_KEYS-1:0]  keyword_hits,
    input logic                          wifi_reinit,
    input logic                          server_connect,
    input logic                          start_send,
    input logic [lkd_pkg::LED_W-1:0]     led_command
);
    import lkd_pkg::*;

    // A stalled result must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(keyword_hits)
            && $stable(led_command))
        else $error("result changed while stalled");

    a_wifi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> wifi_reinit == (keyword_hits[KEY_FAIL] || keyword_hits[KEY_NO_AP]
            || keyword_hits[KEY_STATUS5] || keyword_hits[KEY_GOT_IP]))
        else $error("wifi_reinit disagrees with keyword flags");

    a_actions: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (start_send == (keyword_hits[KEY_STATUS3] || keyword_hits[KEY_SEND]))
            && (server_connect == (keyword_hits[KEY_CWJAP] || keyword_hits[KEY_CLOSED]
            || keyword_hits[KEY_STATUS2] || keyword_hits[KEY_STATUS4])))
        else $error("start_send or server_connect disagrees with keyword flags");

    a_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((led_command == LED_NONE) == (keyword_hits[KEY_CMD4:KEY_CMD1] == '0))
            && (keyword_hits[KEY_CMD4] == (led_command == LED_CMD4)))
        else $error("led_command disagrees with command flags");

endmodule

bind line_keyword_detector_top lkd_checker u_lkd_checker (.*);
